// ----- rtl/core/sga_pkg.sv -----
// Shared widths, reset values and types for the softened gravity accumulator.
// No dependencies; every other file in rtl/core imports this package.
package sga_pkg;

  localparam int FRAC_BITS = 24;
  localparam int POS_W     = 32;
  localparam int MAG_W     = 32;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SOFT_W    = 32;
  localparam int ACC_W     = 48;
  // s2 < 3 * 2^(64-F) + 2^32 < 2^(66-F)
  localparam int S2_W      = 66 - FRAC_BITS;
  localparam int N_W       = S2_W + FRAC_BITS;
  localparam int R_W       = N_W / 2;
  localparam int MA_W      = S2_W;
  localparam int MB_W      = R_W;
  localparam int P_W       = MA_W + MB_W;
  localparam int DEN_W     = P_W;
  localparam int NUM_W     = MAG_W + 2 * FRAC_BITS;

  localparam logic [SOFT_W-1:0] SOFT_RESET = SOFT_W'(370);
  localparam logic [ACC_W-1:0]  MAG_LIMIT  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  SUM_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  SUM_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [ACC_W-1:0] mag;
    logic             clip;
  } sga_div_res_t;

endpackage

// ----- rtl/core/sga_if.sv -----
// Handshake channels of the accumulator: source pairs in, summed results out.
// Depends on sga_pkg for field widths.
interface sga_pair_if import sga_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;
  logic signed [POS_W-1:0] source_x;
  logic signed [POS_W-1:0] source_y;
  logic signed [POS_W-1:0] source_z;
  logic                    last_source;

  modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, last_source, input ready);
  modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                source_z, last_source, output ready);
endinterface

interface sga_result_if import sga_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] accel_x;
  logic signed [ACC_W-1:0] accel_y;
  logic signed [ACC_W-1:0] accel_z;
  logic                    saturated;

  modport source (output valid, accel_x, accel_y, accel_z, saturated, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, saturated, output ready);
endinterface

// ----- rtl/core/sga_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on sga_pkg for operand widths.
module sga_mul import sga_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [MA_W-1:0] a,
  input  logic [MB_W-1:0] b,
  output logic            done,
  output logic [P_W-1:0]  p
);

  localparam int CW = $clog2(MB_W + 1);

  logic [MA_W-1:0] mcand;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [MA_W:0]   upper;

  // low part of p holds the multiplier bits still to be used
  assign upper = {1'b0, p[P_W-1:MB_W]} + (p[0] ? {1'b0, mcand} : {(MA_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        cnt   <= CW'(MB_W);
        mcand <= a;
        p     <= {{MA_W{1'b0}}, b};
      end else if (busy) begin
        p   <= {upper, p[MB_W-1:1]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sga_isqrt.sv -----
// Integer square root, digit by digit: one root bit per cycle.
// Depends on sga_pkg for widths.
module sga_isqrt import sga_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [N_W-1:0] n,
  output logic           done,
  output logic [R_W-1:0] root
);

  localparam int CW = $clog2(R_W + 1);

  logic [N_W-1:0] nsh;
  logic [R_W+1:0] rem;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [R_W+1:0] rem2;
  logic [R_W+1:0] trial;
  logic           ge;

  // remainder stays below 2^R_W until the final step, whose remainder is dropped
  assign rem2  = {rem[R_W-1:0], nsh[N_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(R_W);
        nsh  <= n;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        nsh  <= {nsh[N_W-3:0], 2'b00};
        rem  <= ge ? rem2 - trial : rem2;
        root <= {root[R_W-2:0], ge};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sga_div.sv -----
// Restoring divider, one numerator bit per cycle, with quotient clamp at 2^47.
// Depends on sga_pkg for widths and the result struct.
module sga_div import sga_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [MAG_W-1:0] mag,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output sga_div_res_t     res
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [ACC_W-1:0] q;
  logic             ovf;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem2;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             big;

  assign rem2 = {rem, num[NUM_W-1]};
  assign diff = rem2 - {1'b0, dreg};
  assign ge   = rem2 >= {1'b0, dreg};

  // quotient bits shifted out of the top mean the magnitude is far too large
  assign big      = ovf || (q > MAG_LIMIT);
  assign res.mag  = big ? MAG_LIMIT : q;
  assign res.clip = big;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        num  <= {mag, {(2*FRAC_BITS){1'b0}}};
        dreg <= den;
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        q   <= {q[ACC_W-2:0], ge};
        ovf <= ovf | q[ACC_W-1];
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/softened_gravity_accumulator.sv -----
// Channel  | Dir | Contents
// pair     | in  | target and source positions (Q8.24), last_source mark
// result   | out | saturated acceleration sums (Q23.24), saturated flag
// wr_en    | in  | softening_squared write (wr_data, unsigned Q8.24)
//
// One item at a time: a new pair is accepted only after the last one is through the
// bit-serial units (at FRAC_BITS 24: three squares and one product of 33 steps each on the
// shared multiplier, a 33-step root, three divisions of 32 + 2*FRAC_BITS steps), each
// unit started and finished by a registered pulse; a zero s2 skips the product and divisions.
// rst is synchronous: sums and clip flag clear, softening_squared returns to 370.
// pair.ready is high only while idle; a finished result waits in the output
// register, and a run end stalls only while the previous result is still held.
// Depends on sga_pkg, sga_if, sga_mul, sga_isqrt and sga_div.
module softened_gravity_accumulator import sga_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  sga_pair_if.sink            pair,
  sga_result_if.source        result,
  input  logic                wr_en,
  input  logic [SOFT_W-1:0]   wr_data
);

  typedef enum logic [2:0] {
    IDLE, SQUARE, ROOT, DENOM, DIVIDE, POST
  } state_t;

  state_t            state;
  logic [SOFT_W-1:0] softening;
  logic [MAG_W-1:0]  dmag [3];
  logic              dneg [3];
  logic [ACC_W-1:0]  sum [3];
  logic              clip_flag;
  logic              last;
  logic [S2_W-1:0]   s2;
  logic [DEN_W-1:0]  den;
  logic [1:0]        k;

  logic              mul_go;
  logic              mul_go_next;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic              mul_done;
  logic [P_W-1:0]    mul_p;
  logic              sq_go;
  logic              sq_go_next;
  logic              sq_done;
  logic [R_W-1:0]    sq_root;
  logic              div_go;
  logic              div_go_next;
  logic [MAG_W-1:0]  div_mag;
  logic              div_done;
  sga_div_res_t      div_res;

  logic [DIFF_W-1:0] d_x, d_y, d_z;
  logic [ACC_W:0]    contrib;
  logic [ACC_W:0]    sumw;
  logic              sum_ovf;
  logic [ACC_W-1:0]  sum_next;
  logic              free_out;

  sga_mul u_mul (
    .clk (clk), .rst (rst), .go (mul_go), .a (mul_a), .b (mul_b),
    .done (mul_done), .p (mul_p)
  );

  sga_isqrt u_isqrt (
    .clk (clk), .rst (rst), .go (sq_go), .n ({s2, {FRAC_BITS{1'b0}}}),
    .done (sq_done), .root (sq_root)
  );

  sga_div u_div (
    .clk (clk), .rst (rst), .go (div_go), .mag (div_mag), .den (den),
    .done (div_done), .res (div_res)
  );

  assign d_x = {pair.target_x[POS_W-1], pair.target_x} - {pair.source_x[POS_W-1], pair.source_x};
  assign d_y = {pair.target_y[POS_W-1], pair.target_y} - {pair.source_y[POS_W-1], pair.source_y};
  assign d_z = {pair.target_z[POS_W-1], pair.target_z} - {pair.source_z[POS_W-1], pair.source_z};

  // contribution opposes the offset: subtract when the offset is positive
  assign contrib  = dneg[k] ? {1'b0, div_res.mag} : -{1'b0, div_res.mag};
  assign sumw     = {sum[k][ACC_W-1], sum[k]} + contrib;
  assign sum_ovf  = sumw[ACC_W] ^ sumw[ACC_W-1];
  assign sum_next = sum_ovf ? (sumw[ACC_W] ? SUM_MIN : SUM_MAX) : sumw[ACC_W-1:0];

  assign free_out   = !result.valid || result.ready;
  assign pair.ready = (state == IDLE);

  // start pulses for the serial units
  assign mul_go_next = (state == IDLE && pair.valid) ||
                       (state == SQUARE && mul_done && k != 2'd2) ||
                       (state == ROOT && s2 != '0 && sq_done);
  assign sq_go_next  = (state == SQUARE && mul_done && k == 2'd2);
  assign div_go_next = (state == DENOM && mul_done) ||
                       (state == DIVIDE && div_done && k != 2'd2);

  function automatic logic [MAG_W-1:0] abs_diff(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] a;
    a = d[DIFF_W-1] ? -d : d;
    return a[MAG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      softening    <= SOFT_RESET;
      sum[0]       <= '0;
      sum[1]       <= '0;
      sum[2]       <= '0;
      clip_flag    <= 1'b0;
      result.valid <= 1'b0;
      mul_go       <= 1'b0;
      sq_go        <= 1'b0;
      div_go       <= 1'b0;
    end else begin
      mul_go <= mul_go_next;
      sq_go  <= sq_go_next;
      div_go <= div_go_next;
      if (wr_en) begin
        softening <= wr_data;
      end
      if (result.valid && result.ready && !(state == POST && last)) begin
        result.valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (pair.valid) begin
            dmag[0] <= abs_diff(d_x);
            dmag[1] <= abs_diff(d_y);
            dmag[2] <= abs_diff(d_z);
            dneg[0] <= d_x[DIFF_W-1];
            dneg[1] <= d_y[DIFF_W-1];
            dneg[2] <= d_z[DIFF_W-1];
            last    <= pair.last_source;
            s2      <= S2_W'(softening);
            k       <= 2'd0;
            mul_a   <= MA_W'(abs_diff(d_x));
            mul_b   <= MB_W'(abs_diff(d_x));
            state   <= SQUARE;
          end
        end
        SQUARE: begin
          if (mul_done) begin
            s2 <= s2 + mul_p[FRAC_BITS +: S2_W];
            if (k == 2'd2) begin
              state <= ROOT;
            end else begin
              k      <= k + 2'd1;
              mul_a  <= MA_W'(dmag[k + 2'd1]);
              mul_b  <= MB_W'(dmag[k + 2'd1]);
            end
          end
        end
        ROOT: begin
          // a zero s2 adds nothing; the root started on it is left to finish
          if (s2 == '0) begin
            state <= POST;
          end else if (sq_done) begin
            mul_a  <= s2;
            mul_b  <= sq_root;
            state  <= DENOM;
          end
        end
        DENOM: begin
          if (mul_done) begin
            den     <= mul_p;
            k       <= 2'd0;
            div_mag <= dmag[0];
            state   <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            sum[k]    <= sum_next;
            clip_flag <= clip_flag | div_res.clip | sum_ovf;
            if (k == 2'd2) begin
              state <= POST;
            end else begin
              k       <= k + 2'd1;
              div_mag <= dmag[k + 2'd1];
            end
          end
        end
        POST: begin
          if (!last) begin
            state <= IDLE;
          end else if (free_out) begin
            result.valid     <= 1'b1;
            result.accel_x   <= sum[0];
            result.accel_y   <= sum[1];
            result.accel_z   <= sum[2];
            result.saturated <= clip_flag;
            sum[0]           <= '0;
            sum[1]           <= '0;
            sum[2]           <= '0;
            clip_flag        <= 1'b0;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
